>>> hw/rtl/ds18_pkg.sv
package ds18_pkg;

  // Scratchpad layout
  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] IDX_RAW_LOW   = 4'd0;
  localparam logic [IDX_W-1:0] IDX_RAW_HIGH  = 4'd1;
  localparam logic [IDX_W-1:0] IDX_COUNT_REM = 4'd6;
  localparam logic [IDX_W-1:0] IDX_RESERVED  = 4'd7;
  localparam logic [IDX_W-1:0] IDX_LAST      = 4'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] IDX_DONE      = 4'(FRAME_BYTES);

  localparam logic [7:0] CRC_POLY       = 8'h8C;
  localparam logic [7:0] RESERVED_VALUE = 8'h10;
  localparam logic [7:0] S20_FAMILY     = 8'h10;
  localparam logic [7:0] FAMILY_RESET   = 8'd40;

  localparam logic signed [15:0] ERROR_TEMP = -16'sd6000;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR  = 2'd1;
  localparam logic [1:0] STATUS_RESV_ERR = 2'd2;

  // Captured scratchpad bytes
  typedef struct packed {
    logic [7:0] low;
    logic [7:0] high;
    logic [7:0] count_remain;
  } raw_bytes_t;

  // Per-item frame status toward the result stage
  typedef struct packed {
    logic done;
    logic crc_zero;
    logic reserved_ok;
  } frame_stat_t;

endpackage

>>> hw/rtl/ds18x20_scratchpad_decode_unit.sv
// Scratchpad decoder for DS18x20-style temperature sensors. Feed the nine
// scratchpad bytes one item at a time, byte 0 first, with tuser high on byte 0
// of each frame (a high tuser mid-frame drops the frame in progress). After
// byte 8 one result item comes out: tdata is the temperature in 0.01 degree
// units, tuser the status (0 ok, 1 CRC error, 2 byte 7 not 0x10, both errors
// report -6000). Bytes after a complete frame without a new start are dropped.
// The block takes one item per cycle while the result side does not stall it;
// a byte goes through an input register, the CRC and temperature logic and a
// result register. A result held on the output stalls the input once the
// input register is full. The family register selects the S20 count-remain
// correction when set to 0x10; write it only while idle.
module ds18x20_scratchpad_decode_unit (
  input  logic        clk,
  input  logic        rst,
  // Configuration: sensor_family
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] temperature_centi
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import ds18_pkg::*;

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              in_start;
  logic              advance;
  logic [7:0]        sensor_family;
  frame_stat_t       stat;
  raw_bytes_t        raw;
  logic signed [15:0] temp_ok;
  logic signed [15:0] temp_next;
  logic [1:0]        status_next;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_family <= FAMILY_RESET;
    end else if (cfg_wr_en) begin
      sensor_family <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  ds18_frame u_frame (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .data  (in_byte),
    .start (in_start),
    .stat  (stat),
    .raw   (raw)
  );

  ds18_temp_conv u_conv (
    .raw               (raw),
    .sensor_family     (sensor_family),
    .temperature_centi (temp_ok)
  );

  // Result selection
  always_comb begin
    if (!stat.crc_zero) begin
      temp_next   = ERROR_TEMP;
      status_next = STATUS_CRC_ERR;
    end else if (!stat.reserved_ok) begin
      temp_next   = ERROR_TEMP;
      status_next = STATUS_RESV_ERR;
    end else begin
      temp_next   = temp_ok;
      status_next = STATUS_OK;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (stat.done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      m_axis_tdata <= temp_next;
      m_axis_tuser <= status_next;
    end
  end

endmodule

>>> hw/rtl/ds18_frame.sv
module ds18_frame (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             data,
  input  logic                   start,
  output ds18_pkg::frame_stat_t  stat,
  output ds18_pkg::raw_bytes_t   raw
);
  import ds18_pkg::*;

  logic [7:0]       crc_acc;
  logic [7:0]       crc_next;
  logic [IDX_W-1:0] byte_index;
  logic [IDX_W-1:0] idx_eff;
  logic [7:0]       crc_base;
  logic             active;
  logic             reserved_ok;

  // Reflected CRC-8, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    c = crc ^ d;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Frame start restarts the count and the CRC
  assign idx_eff  = start ? '0 : byte_index;
  assign crc_base = start ? '0 : crc_acc;
  assign active   = (idx_eff < IDX_DONE);
  assign crc_next = crc8_byte(crc_base, data);

  assign stat.done        = step && active && (idx_eff == IDX_LAST);
  assign stat.crc_zero    = (crc_next == 8'h00);
  assign stat.reserved_ok = reserved_ok;

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc          <= '0;
      byte_index       <= '0;
      raw.low          <= '0;
      raw.high         <= '0;
      raw.count_remain <= '0;
      reserved_ok      <= 1'b0;
    end else if (step) begin
      if (active) begin
        crc_acc    <= crc_next;
        byte_index <= idx_eff + 1'b1;
        case (idx_eff)
          IDX_RAW_LOW:   raw.low <= data;
          IDX_RAW_HIGH:  raw.high <= data;
          IDX_COUNT_REM: raw.count_remain <= data;
          IDX_RESERVED:  reserved_ok <= (data == RESERVED_VALUE);
          default: ;
        endcase
      end else begin
        crc_acc    <= crc_base;
        byte_index <= idx_eff;
      end
    end
  end

endmodule

>>> hw/rtl/ds18_temp_conv.sv
module ds18_temp_conv (
  input  ds18_pkg::raw_bytes_t raw,
  input  logic [7:0]           sensor_family,
  output logic signed [15:0]   temperature_centi
);
  import ds18_pkg::*;

  logic              s20;
  logic [7:0]        hi;
  logic [7:0]        lo;
  logic [15:0]       raw_val;
  logic              neg;
  logic [15:0]       mag;
  logic [17:0]       scaled;
  logic signed [19:0] signed_t;
  logic signed [19:0] adj_t;

  assign s20 = (sensor_family == S20_FAMILY);

  // S20 rebuild from count_remain
  always_comb begin
    if (s20) begin
      hi = (raw.high & 8'hF8) + ((raw.low >> 5) & 8'h07);
      lo = ((raw.low << 3) & 8'hF0) + (8'd16 - raw.count_remain);
    end else begin
      hi = raw.high;
      lo = raw.low;
    end
  end

  assign raw_val = {hi, lo};
  assign neg     = hi[7];
  assign mag     = neg ? (16'd0 - raw_val) : raw_val;

  // m*6 + m/4
  assign scaled = {mag, 2'b00} + {1'b0, mag, 1'b0} + {4'b0000, mag[15:2]};

  assign signed_t = neg ? -$signed({2'b00, scaled}) : $signed({2'b00, scaled});
  assign adj_t    = s20 ? (signed_t - 20'sd25) : signed_t;

  // Saturate to 16 bits
  always_comb begin
    if (adj_t > 20'sd32767) begin
      temperature_centi = 16'sh7FFF;
    end else if (adj_t < -20'sd32768) begin
      temperature_centi = -16'sh8000;
    end else begin
      temperature_centi = adj_t[15:0];
    end
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ds18_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int PHASES        = 5;
  localparam int SETTLE_CYCLES = 4;    // extra wait once no results are pending
  localparam int DRAIN_LIMIT   = 400;
  localparam int HOLD_CYCLES   = 80;
  localparam int SCRIPT_ROWS   = 20;
  localparam int S20_OFFSET    = 25;
  localparam logic signed [15:0] TEMP_FLOOR = 16'sh8000;

  // How the directed script fills a check byte
  typedef enum logic [1:0] {CRC_AS_IS, CRC_FIX, CRC_BREAK} crc_mode_t;

  typedef struct packed {
    logic [7:0]         data;
    logic               start;
    crc_mode_t          crc_mode;
    logic               typed;    // expectation given in the row itself
    logic signed [15:0] temp;
    logic [1:0]         status;
  } script_row_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [1:0]         status;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic        s_axis_tuser = 1'b0;    // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [15:0] temperature_centi
  logic [1:0]  m_axis_tuser;           // [1:0] status

  ds18x20_scratchpad_decode_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Directed script: a frame without start flag after reset and a bad check
  // byte, a stray byte after the full frame, an abandoned frame, then the most
  // negative raw value.
  script_row_t script [SCRIPT_ROWS] = '{
    '{8'hFF, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'hFF, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'h00, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'hFF, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'h00, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'hFF, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'hFF, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'h00, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'h00, 1'b0, CRC_BREAK, 1'b1, ERROR_TEMP, STATUS_CRC_ERR},
    '{8'h5A, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'h33, 1'b1, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'h00, 1'b1, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'h80, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'hFF, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'h00, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'hFF, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'h00, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'h00, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'h10, 1'b0, CRC_AS_IS, 1'b0, 16'sd0, STATUS_OK},
    '{8'h00, 1'b0, CRC_FIX,   1'b1, TEMP_FLOOR, STATUS_OK}
  };

  logic [7:0] phase_family [PHASES] = '{S20_FAMILY, 8'h00, 8'hFF, FAMILY_RESET, S20_FAMILY};

  // Predictor state
  logic [7:0] family_q;
  logic [7:0] crc_q;
  logic [3:0] idx_q;
  logic [7:0] low_q, high_q, remain_q;
  logic       resv_ok_q;

  reading_t pending_readings [$];
  int errors = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int input_stalls = 0;
  int hold_done = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #2000000;
    $display("ds18x20_scratchpad_decode_unit: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  // Reflected CRC-8, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] r;
    r = c ^ d;
    for (int k = 0; k < 8; k++)
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Raw scratchpad value to hundredths of a degree, saturated to 16 bits
  function automatic logic signed [15:0] centi_degrees(input logic [7:0] lo, input logic [7:0] hi,
                                                       input logic [7:0] cr, input logic s20);
    logic [7:0] l, h;
    int raw, mag, t;
    l = lo;
    h = hi;
    if (s20) begin
      h = (hi & 8'hF8) + ((lo >> 5) & 8'h07);
      l = ((lo << 3) & 8'hF0) + (8'd16 - cr);
    end
    raw = int'({h, l});
    mag = h[7] ? 65536 - raw : raw;
    t = mag * 6 + mag / 4;
    if (h[7]) t = -t;
    if (s20) t = t - S20_OFFSET;
    if (t > 32767) t = 32767;
    else if (t < -32768) t = -32768;
    return 16'(t);
  endfunction

  task automatic reset_predictor();
    family_q  = FAMILY_RESET;
    crc_q     = 8'h00;
    idx_q     = '0;
    low_q     = 8'h00;
    high_q    = 8'h00;
    remain_q  = 8'h00;
    resv_ok_q = 1'b0;
  endtask

  // Fold one accepted byte into the predicted frame state
  task automatic absorb_byte(input logic [7:0] d, input logic st, output logic took,
                             output logic done, output reading_t r);
    took = 1'b0;
    done = 1'b0;
    r = '0;
    if (st) begin
      crc_q = 8'h00;
      idx_q = '0;
    end
    if (idx_q < IDX_DONE) begin
      took = 1'b1;
      crc_q = crc8_step(crc_q, d);
      case (idx_q)
        IDX_RAW_LOW:   low_q = d;
        IDX_RAW_HIGH:  high_q = d;
        IDX_COUNT_REM: remain_q = d;
        IDX_RESERVED:  resv_ok_q = (d == RESERVED_VALUE);
        default: ;
      endcase
      idx_q = idx_q + 4'd1;
      if (idx_q == IDX_DONE) begin
        done = 1'b1;
        if (crc_q != 8'h00) begin
          r.temp = ERROR_TEMP;
          r.status = STATUS_CRC_ERR;
        end else if (!resv_ok_q) begin
          r.temp = ERROR_TEMP;
          r.status = STATUS_RESV_ERR;
        end else begin
          r.temp = centi_degrees(low_q, high_q, remain_q, family_q == S20_FAMILY);
          r.status = STATUS_OK;
        end
      end
    end
  endtask

  function automatic int idle_gap();
    int n;
    n = 0;
    if (idle_on)
      while ($urandom_range(99) < 20) n++;
    return n;
  endfunction

  // Offer one item, wait for it to be taken, then queue what it predicts
  task automatic send_byte(input logic [7:0] d, input logic st, input logic typed,
                           input reading_t typed_r);
    int gap;
    logic took, done;
    reading_t r;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= st;
    do @(posedge clk); while (!s_axis_tready);
    absorb_byte(d, st, took, done, r);
    if (took) bytes_taken++;
    if (done) pending_readings.push_back(typed ? typed_r : r);
  endtask

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      4: return 16'h07D0;
      5: return 16'hFC90;
      6: return 16'h0550;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Mostly a well-formed frame; sometimes a wrong byte 7 or check byte
  task automatic send_frame();
    logic [7:0] fb [9];
    logic [15:0] raw;
    logic [7:0] c;
    raw = pick_raw();
    fb[0] = raw[7:0];
    fb[1] = raw[15:8];
    for (int k = 2; k < 6; k++) fb[k] = 8'($urandom_range(255));
    fb[6] = ($urandom_range(1) == 0) ? 8'($urandom_range(16)) : 8'($urandom_range(255));
    fb[7] = ($urandom_range(99) < 85) ? RESERVED_VALUE : 8'($urandom_range(255));
    c = 8'h00;
    for (int k = 0; k < 8; k++) c = crc8_step(c, fb[k]);
    fb[8] = ($urandom_range(99) < 85) ? c : c ^ (8'h01 << $urandom_range(7));
    for (int k = 0; k < 9; k++) send_byte(fb[k], k == 0, 1'b0, '0);
  endtask

  // Loose bytes with random start flags: truncated and stray frames
  task automatic send_noise();
    int n;
    n = $urandom_range(12, 1);
    for (int k = 0; k < n; k++)
      send_byte(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b0, '0);
  endtask

  // Stop offering and let every expected result come out
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_family(input logic [7:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    family_q = v;
  endtask

  // Result side ready, dropped at random while idling is on, with one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          hold_done++;
        end
      end
      m_axis_tready <= !(idle_on && $urandom_range(99) < 20);
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && !s_axis_tready) input_stalls++;
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin : check_result
    reading_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected result temp=%0d status=%0d",
                                  $signed(m_axis_tdata), m_axis_tuser));
      end else begin
        want = pending_readings.pop_front();
        if (m_axis_tdata !== want.temp)
          report_mismatch($sformatf("temperature %0d, expected %0d",
                                    $signed(m_axis_tdata), want.temp));
        if (m_axis_tuser !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", m_axis_tuser, want.status));
        results_seen++;
        status_seen[want.status]++;
      end
    end
  end

  initial begin : stimulus
    script_row_t row;
    reading_t typed_r;
    logic [7:0] b;
    int quota;
    reset_predictor();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, reset family
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      row = script[i];
      b = row.data;
      if (row.crc_mode == CRC_FIX) b = crc_q;
      else if (row.crc_mode == CRC_BREAK) b = crc_q ^ 8'h01;
      typed_r.temp = row.temp;
      typed_r.status = row.status;
      send_byte(b, row.start, row.typed, typed_r);
    end

    // Random part, one family per phase
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_family(phase_family[p]);
      idle_on = (p != 2);
      if (p == 1) hold_req = 1'b1;
      quota = bytes_taken + RANDOM_ITEMS / PHASES;
      while (bytes_taken < quota) begin
        if ($urandom_range(99) < 80) send_frame();
        else send_noise();
      end
    end

    drain_results();
    if (pending_readings.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_readings.size()));
    $display("Took %0d bytes, checked %0d readings: %0d ok, %0d CRC errors, %0d bad byte 7",
             bytes_taken, results_seen, status_seen[0], status_seen[1], status_seen[2]);
    $display("Families: reset, S20, 0x00, 0xFF; %0d cycles input stalled, %0d held off",
             input_stalls, hold_done);
    if (errors == 0)
      $display("ds18x20_scratchpad_decode_unit: match");
    else
      $display("ds18x20_scratchpad_decode_unit: mismatch");
    $finish;
  end

endmodule
